// ===== rtl/bgd_pkg.sv =====
`default_nettype none
package bgd_pkg;

	// most events a single poll can produce
	localparam int MaxEv = 5;
	localparam int EvIdxW = $clog2(MaxEv);
	localparam int EvCntW = $clog2(MaxEv + 1);

	// number of candidate events examined per poll
	localparam int NumCand = 8;
	localparam int CandCntW = $clog2(NumCand + 1);

	// apb address width and register indexes
	localparam int AddrW = 5;
	localparam int DataW = 32;

	typedef enum logic [2:0] {
		REG_ACTIVE_LOW    = 3'd0,
		REG_HOLD_TIME     = 3'd1,
		REG_REPEAT_ENABLE = 3'd2,
		REG_REPEAT_TIME   = 3'd3,
		REG_DC_WINDOW     = 3'd4,
		REG_HOLD_BACK     = 3'd5
	} reg_idx_t;

	// reset values of the registers
	localparam logic [15:0] HoldTimeRst = 16'd1000;
	localparam logic [15:0] RepeatTimeRst = 16'd200;

	typedef enum logic [2:0] {
		EV_CHANGED  = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_RELEASED = 3'd2,
		EV_CLICK    = 3'd3,
		EV_DOUBLE   = 3'd4,
		EV_LONG     = 3'd5,
		EV_HOLD     = 3'd6,
		EV_REPEAT   = 3'd7
	} event_code_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        pin_level;
	} poll_item_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic       last_event;
	} gesture_item_t;

	typedef struct packed {
		logic        active_low;
		logic [15:0] hold_time;
		logic        repeat_enable;
		logic [15:0] repeat_time;
		logic [15:0] double_click_window;
		logic        hold_back_click;
	} cfg_t;

	// event list of one poll, handed from front to back
	typedef struct packed {
		logic [MaxEv-1:0][2:0] codes;
		logic [EvCntW-1:0]     count;
	} ev_list_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// ===== rtl/bgd_front.sv =====
`default_nettype none
module bgd_front import bgd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       poll_valid,
	output logic            poll_ready,
	input  wire poll_item_t poll,
	input  wire q_status_t  q_stat,
	output logic            push,
	output ev_list_t        push_list
);

	logic        prev_level_q;
	logic [31:0] press_time_q;
	logic [31:0] repeat_stamp_q;
	logic [1:0]  click_tally_q;
	logic        holding_q;

	logic        accept;
	logic        down;
	logic        changed;
	logic        pressed;
	logic        released;
	logic [31:0] dt_press;
	logic [31:0] dt_rep;
	logic        expire;
	logic [1:0]  tally_a;
	logic [1:0]  tally_b;
	logic [1:0]  tally_next;
	logic        long_rel;
	logic        rel2_valid;
	event_code_t rel2_code;
	logic        rep;
	logic        hold;
	logic        hold_rep;

	logic [NumCand-1:0] cand_flag;
	event_code_t        cand_code [NumCand];
	logic [CandCntW-1:0] cnt;

	assign poll_ready = !q_stat.full;
	assign accept = poll_valid && poll_ready;

	// level classification and time differences
	assign down = poll.pin_level ^ cfg.active_low;
	assign changed = down != prev_level_q;
	assign pressed = changed && down;
	assign released = changed && !down;
	assign dt_press = poll.now_ms - press_time_q;
	assign dt_rep = poll.now_ms - repeat_stamp_q;

	// double-click window expiry
	assign expire = !down && (click_tally_q != 2'd0) &&
		(dt_press >= {16'd0, cfg.double_click_window});
	assign tally_a = expire ? 2'd0 : click_tally_q;
	assign tally_b = (tally_a == 2'd3) ? 2'd3 : tally_a + 2'd1;
	assign long_rel = (cfg.hold_time != 16'd0) && (dt_press >= {16'd0, cfg.hold_time});

	// second event of a release
	always_comb begin
		rel2_valid = 1'b0;
		rel2_code = EV_CLICK;
		tally_next = tally_a;
		if (released) begin
			if (long_rel) begin
				rel2_valid = 1'b1;
				rel2_code = EV_LONG;
			end else if (cfg.double_click_window != 16'd0) begin
				tally_next = tally_b;
				if (tally_b == 2'd1 && !cfg.hold_back_click) begin
					rel2_valid = 1'b1;
					rel2_code = EV_CLICK;
				end else if (tally_b == 2'd2) begin
					rel2_valid = 1'b1;
					rel2_code = EV_DOUBLE;
				end
			end else begin
				rel2_valid = 1'b1;
				rel2_code = holding_q ? EV_LONG : EV_CLICK;
			end
		end
	end

	// hold and repeat while down; a press poll cannot reach hold
	assign rep = down && cfg.repeat_enable && holding_q &&
		(dt_rep >= {16'd0, cfg.repeat_time});
	assign hold = down && !holding_q && !pressed && (cfg.hold_time != 16'd0) &&
		(dt_press >= {16'd0, cfg.hold_time});
	assign hold_rep = hold && cfg.repeat_enable;

	// candidate events in emission order
	always_comb begin
		cand_flag[0] = changed;
		cand_code[0] = EV_CHANGED;
		cand_flag[1] = expire && (click_tally_q == 2'd1) && cfg.hold_back_click;
		cand_code[1] = EV_CLICK;
		cand_flag[2] = pressed;
		cand_code[2] = EV_PRESSED;
		cand_flag[3] = released;
		cand_code[3] = EV_RELEASED;
		cand_flag[4] = rel2_valid;
		cand_code[4] = rel2_code;
		cand_flag[5] = rep;
		cand_code[5] = EV_REPEAT;
		cand_flag[6] = hold;
		cand_code[6] = EV_HOLD;
		cand_flag[7] = hold_rep;
		cand_code[7] = EV_REPEAT;
	end

	// pack the raised candidates into the event list
	always_comb begin
		cnt = '0;
		push_list.codes = '0;
		for (int i = 0; i < NumCand; i++) begin
			if (cand_flag[i]) begin
				if (cnt < CandCntW'(MaxEv)) begin
					push_list.codes[cnt[EvIdxW-1:0]] = cand_code[i];
				end
				cnt = cnt + CandCntW'(1);
			end
		end
		push_list.count = (cnt > CandCntW'(MaxEv)) ? EvCntW'(MaxEv) : cnt[EvCntW-1:0];
	end

	assign push = accept && (cnt != '0);

	// per-button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			press_time_q <= '0;
			repeat_stamp_q <= '0;
			click_tally_q <= '0;
			holding_q <= 1'b0;
		end else if (accept) begin
			prev_level_q <= down;
			click_tally_q <= tally_next;
			if (pressed) begin
				press_time_q <= poll.now_ms;
			end
			if (rep || hold_rep) begin
				repeat_stamp_q <= poll.now_ms;
			end
			if (released) begin
				holding_q <= 1'b0;
			end else if (hold) begin
				holding_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bgd_queue.sv =====
`default_nettype none
module bgd_queue import bgd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire ev_list_t push_list,
	input  wire logic     pop,
	output ev_list_t      head,
	output q_status_t     q_stat
);

	ev_list_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign q_stat.full = fill_q == 2'd2;
	assign q_stat.empty = fill_q == 2'd0;
	assign head = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_list;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bgd_back.sv =====
`default_nettype none
module bgd_back import bgd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ev_list_t  head,
	input  wire q_status_t q_stat,
	output logic           pop,
	output logic           gesture_valid,
	input  wire logic      gesture_ready,
	output gesture_item_t  gesture
);

	ev_list_t          cur_q;
	logic [EvIdxW-1:0] idx_q;
	logic              busy_q;
	logic              is_last;
	logic              done;
	logic              load;

	assign gesture_valid = busy_q;
	assign is_last = idx_q == EvIdxW'(cur_q.count - EvCntW'(1));
	assign gesture.event_code = cur_q.codes[idx_q];
	assign gesture.last_event = is_last;

	// take the next list when idle or when the last item of this one leaves
	assign done = busy_q && gesture_ready && is_last;
	assign load = !busy_q || done;
	assign pop = load && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= !q_stat.empty;
			idx_q <= '0;
		end else if (gesture_ready) begin
			idx_q <= idx_q + EvIdxW'(1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/button_gesture_detector.sv =====
// path: a poll's event list is written into the queue, then loaded into the back end
// throughput: one poll per cycle while the queue is not full; events leave one per cycle
// from the back end while gesture_ready is high, one event at a time; a two-entry list queue
// lets the front keep taking polls meanwhile, polls with no event skip the queue
// reset: arst_n clears button state, queue and back end, and loads register defaults
`default_nettype none
module button_gesture_detector import bgd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	input  wire logic             poll_valid,
	output logic                  poll_ready,
	input  wire poll_item_t       poll,
	output logic                  gesture_valid,
	input  wire logic             gesture_ready,
	output gesture_item_t         gesture
);

	cfg_t      cfg_q;
	logic      cfg_wr;
	reg_idx_t  reg_idx;
	logic      push;
	logic      pop;
	ev_list_t  push_list;
	ev_list_t  head;
	q_status_t q_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low <= 1'b0;
			cfg_q.hold_time <= HoldTimeRst;
			cfg_q.repeat_enable <= 1'b0;
			cfg_q.repeat_time <= RepeatTimeRst;
			cfg_q.double_click_window <= 16'd0;
			cfg_q.hold_back_click <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ACTIVE_LOW:    cfg_q.active_low <= pwdata[0];
				REG_HOLD_TIME:     cfg_q.hold_time <= pwdata[15:0];
				REG_REPEAT_ENABLE: cfg_q.repeat_enable <= pwdata[0];
				REG_REPEAT_TIME:   cfg_q.repeat_time <= pwdata[15:0];
				REG_DC_WINDOW:     cfg_q.double_click_window <= pwdata[15:0];
				REG_HOLD_BACK:     cfg_q.hold_back_click <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_ACTIVE_LOW:    prdata = {31'd0, cfg_q.active_low};
			REG_HOLD_TIME:     prdata = {16'd0, cfg_q.hold_time};
			REG_REPEAT_ENABLE: prdata = {31'd0, cfg_q.repeat_enable};
			REG_REPEAT_TIME:   prdata = {16'd0, cfg_q.repeat_time};
			REG_DC_WINDOW:     prdata = {16'd0, cfg_q.double_click_window};
			REG_HOLD_BACK:     prdata = {31'd0, cfg_q.hold_back_click};
			default:           prdata = '0;
		endcase
	end

	bgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.poll_valid (poll_valid),
		.poll_ready (poll_ready),
		.poll       (poll),
		.q_stat     (q_stat),
		.push       (push),
		.push_list  (push_list)
	);

	bgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_list (push_list),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	bgd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.gesture_valid (gesture_valid),
		.gesture_ready (gesture_ready),
		.gesture       (gesture)
	);

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bgd_pkg::*;

	localparam int DrainGap = 4;
	localparam int QuietLimit = 1000;
	localparam int NumPhases = 6;
	localparam int PollsPerPhase = 56;

	// one row of the directed table: a register write or a poll
	typedef struct packed {
		logic              is_cfg;
		reg_idx_t          idx;
		logic [31:0]       val;
		logic              pin;
		logic              typed;
		logic [2:0]        n_ev;
		event_code_t [0:2] codes;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrW-1:0]     paddr;
	logic [DataW-1:0]     pwdata;
	logic [DataW-1:0]     prdata;
	logic                 pready;
	logic                 poll_valid;
	logic                 poll_ready;
	poll_item_t           poll;
	logic                 gesture_valid;
	logic                 gesture_ready;
	gesture_item_t        gesture;

	// shadow of the registers and of the button state
	cfg_t                 cfg_sh;
	logic                 lvl_q;
	logic [31:0]          press_at;
	logic [31:0]          rep_at;
	logic [1:0]           tally;
	logic                 held;

	event_code_t          poll_events[$];
	gesture_item_t        gest_exp[$];
	step_row_t            steps[$];
	int                   n_bad = 0;
	int                   burst_left = 0;
	int                   quiet_cycles = 0;
	logic [15:0]          rdy_pat = 16'hFFFF;
	int                   rdy_ph = 0;
	gesture_item_t        want;

	button_gesture_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.poll_valid(poll_valid),
		.poll_ready(poll_ready),
		.poll(poll),
		.gesture_valid(gesture_valid),
		.gesture_ready(gesture_ready),
		.gesture(gesture)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void flag_mismatch(string what, int want_v, int got_v);
		n_bad++;
		if (n_bad <= 10)
			$display("mismatch %s: expected %0d, got %0d at %0t", what, want_v, got_v, $time);
	endfunction

	function automatic void push_event(event_code_t c);
		if (poll_events.size() < MaxEv)
			poll_events.insert(poll_events.size(), c);
	endfunction

	// append one row to the directed table
	function automatic void add_step(step_row_t r);
		steps.insert(steps.size(), r);
	endfunction

	// gesture events caused by one poll, in order
	function automatic void predict_gestures(poll_item_t p);
		logic down;
		logic chg;
		poll_events.delete();
		down = p.pin_level ^ cfg_sh.active_low;
		chg = (down != lvl_q);
		lvl_q = down;
		if (chg)
			push_event(EV_CHANGED);

		// window over: forget counted clicks, maybe release a held-back click
		if (!down && tally != 2'd0 &&
		    p.now_ms - press_at >= {16'd0, cfg_sh.double_click_window}) begin
			if (tally == 2'd1 && cfg_sh.hold_back_click)
				push_event(EV_CLICK);
			tally = 2'd0;
		end

		if (chg && down) begin
			press_at = p.now_ms;
			push_event(EV_PRESSED);
		end

		if (chg && !down) begin
			push_event(EV_RELEASED);
			if (cfg_sh.hold_time != 16'd0 &&
			    p.now_ms - press_at >= {16'd0, cfg_sh.hold_time}) begin
				push_event(EV_LONG);
			end else if (cfg_sh.double_click_window != 16'd0) begin
				if (tally != 2'd3)
					tally = tally + 2'd1;
				if (tally == 2'd1 && !cfg_sh.hold_back_click)
					push_event(EV_CLICK);
				if (tally == 2'd2)
					push_event(EV_DOUBLE);
			end else begin
				push_event(held ? EV_LONG : EV_CLICK);
			end
			held = 1'b0;
		end

		// hold and auto-repeat while down
		if (down) begin
			if (cfg_sh.repeat_enable && held &&
			    p.now_ms - rep_at >= {16'd0, cfg_sh.repeat_time}) begin
				rep_at = p.now_ms;
				push_event(EV_REPEAT);
			end
			if (!held && cfg_sh.hold_time != 16'd0 &&
			    p.now_ms - press_at >= {16'd0, cfg_sh.hold_time}) begin
				push_event(EV_HOLD);
				held = 1'b1;
				if (cfg_sh.repeat_enable) begin
					rep_at = p.now_ms;
					push_event(EV_REPEAT);
				end
			end
		end
	endfunction

	function automatic step_row_t poll_row(logic [31:0] t, logic pin);
		step_row_t r;
		r = '0;
		r.val = t;
		r.pin = pin;
		return r;
	endfunction

	function automatic step_row_t seen_row(logic [31:0] t, logic pin, logic [2:0] n,
		event_code_t c0, event_code_t c1, event_code_t c2);
		step_row_t r;
		r = poll_row(t, pin);
		r.typed = 1'b1;
		r.n_ev = n;
		r.codes[0] = c0;
		r.codes[1] = c1;
		r.codes[2] = c2;
		return r;
	endfunction

	function automatic step_row_t cfg_row(reg_idx_t ri, logic [31:0] v);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = ri;
		r.val = v;
		return r;
	endfunction

	// apb write: setup then access
	task automatic write_reg(reg_idx_t ri, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'({ri, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (ri)
			REG_ACTIVE_LOW:    cfg_sh.active_low = v[0];
			REG_HOLD_TIME:     cfg_sh.hold_time = v[15:0];
			REG_REPEAT_ENABLE: cfg_sh.repeat_enable = v[0];
			REG_REPEAT_TIME:   cfg_sh.repeat_time = v[15:0];
			REG_DC_WINDOW:     cfg_sh.double_click_window = v[15:0];
			REG_HOLD_BACK:     cfg_sh.hold_back_click = v[0];
			default: ;
		endcase
	endtask

	// stop sending and wait until the block has gone quiet
	task automatic settle();
		poll_valid <= 1'b0;
		burst_left = 0;
		while (gest_exp.size() != 0)
			@(posedge clk);
		repeat (DrainGap) @(posedge clk);
	endtask

	// send one poll in bursts with random gaps, then queue its events
	task automatic send_poll(step_row_t r);
		poll_item_t    p;
		gesture_item_t g;
		int            gap;
		int            k;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				poll_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		p.now_ms = r.val;
		p.pin_level = r.pin;
		poll <= p;
		poll_valid <= 1'b1;
		@(posedge clk);
		while (!poll_ready)
			@(posedge clk);
		burst_left--;
		predict_gestures(p);
		if (r.typed) begin
			poll_events.delete();
			for (k = 0; k < r.n_ev; k++)
				poll_events.insert(poll_events.size(), r.codes[k]);
		end
		for (k = 0; k < poll_events.size(); k++) begin
			g.event_code = poll_events[k];
			g.last_event = (k == poll_events.size() - 1);
			gest_exp.insert(gest_exp.size(), g);
		end
	endtask

	// receiver: stall pattern and event check
	always @(posedge clk) begin
		if (arst_n) begin
			if (gesture_valid && gesture_ready) begin
				if (gest_exp.size() == 0) begin
					flag_mismatch("unexpected event", -1, gesture.event_code);
				end else begin
					want = gest_exp.pop_front();
					if (gesture.event_code !== want.event_code)
						flag_mismatch("event_code", want.event_code, gesture.event_code);
					if (gesture.last_event !== want.last_event)
						flag_mismatch("last_event", want.last_event, gesture.last_event);
				end
			end
			if (rdy_ph == 0) begin
				case ($urandom_range(0, 3))
					0: rdy_pat = 16'hFFFF;
					1: rdy_pat = 16'h00FF;
					2: rdy_pat = 16'h5555;
					default: rdy_pat = 16'($urandom) | 16'h8001;
				endcase
			end
			gesture_ready <= rdy_pat[rdy_ph];
			rdy_ph = (rdy_ph + 1) % 16;
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((poll_valid && poll_ready) || (gesture_valid && gesture_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("FAIL button_gesture_detector");
				$finish;
			end
		end
	end

	initial begin
		int          i;
		int          ph;
		int          k;
		int          r;
		reg_idx_t    ri;
		logic        wide;
		logic [31:0] v;
		logic [31:0] t_now;
		logic        pin_raw;
		int          sel;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		poll_valid <= 1'b0;
		poll <= '0;
		gesture_ready <= 1'b0;

		// state after reset
		cfg_sh = '0;
		cfg_sh.hold_time = HoldTimeRst;
		cfg_sh.repeat_time = RepeatTimeRst;
		lvl_q = 1'b0;
		press_at = '0;
		rep_at = '0;
		tally = 2'd0;
		held = 1'b0;

		// reset defaults: quiet poll, press at time zero, hold, long, click, wrap
		add_step(seen_row(32'd0, 1'b0, 3'd0, EV_CHANGED, EV_CHANGED, EV_CHANGED));
		add_step(seen_row(32'd0, 1'b1, 3'd2, EV_CHANGED, EV_PRESSED, EV_CHANGED));
		add_step(seen_row(32'd999, 1'b1, 3'd0, EV_CHANGED, EV_CHANGED, EV_CHANGED));
		add_step(seen_row(32'd1000, 1'b1, 3'd1, EV_HOLD, EV_CHANGED, EV_CHANGED));
		add_step(seen_row(32'd1500, 1'b0, 3'd3, EV_CHANGED, EV_RELEASED, EV_LONG));
		add_step(seen_row(32'd1600, 1'b1, 3'd2, EV_CHANGED, EV_PRESSED, EV_CHANGED));
		add_step(seen_row(32'd1700, 1'b0, 3'd3, EV_CHANGED, EV_RELEASED, EV_CLICK));
		add_step(seen_row(32'hFFFF_FFF0, 1'b1, 3'd2, EV_CHANGED, EV_PRESSED,
			EV_CHANGED));
		add_step(seen_row(32'h0000_0400, 1'b1, 3'd1, EV_HOLD, EV_CHANGED, EV_CHANGED));
		add_step(seen_row(32'hFFFF_FFFF, 1'b0, 3'd3, EV_CHANGED, EV_RELEASED, EV_LONG));
		// double click, saturated clicks, hold with repeat at once, zero repeat interval
		add_step(cfg_row(REG_DC_WINDOW, 32'd300));
		add_step(cfg_row(REG_REPEAT_ENABLE, 32'd1));
		add_step(cfg_row(REG_REPEAT_TIME, 32'd0));
		add_step(poll_row(32'd2000, 1'b1));
		add_step(poll_row(32'd2050, 1'b0));
		add_step(poll_row(32'd2100, 1'b1));
		add_step(poll_row(32'd2150, 1'b0));
		add_step(poll_row(32'd2200, 1'b1));
		add_step(poll_row(32'd2250, 1'b0));
		add_step(poll_row(32'd3000, 1'b1));
		add_step(poll_row(32'd4000, 1'b1));
		add_step(poll_row(32'd4000, 1'b1));
		add_step(poll_row(32'd4001, 1'b0));
		// pull-up wiring takes effect at the next poll; held-back click at window end
		add_step(cfg_row(REG_HOLD_BACK, 32'd1));
		add_step(cfg_row(REG_ACTIVE_LOW, 32'd1));
		add_step(cfg_row(REG_HOLD_TIME, 32'd0));
		add_step(cfg_row(REG_REPEAT_TIME, 32'd65535));
		add_step(cfg_row(REG_DC_WINDOW, 32'd65535));
		add_step(poll_row(32'd5000, 1'b0));
		add_step(poll_row(32'd5010, 1'b1));
		add_step(poll_row(32'd70600, 1'b1));
		add_step(poll_row(32'd70700, 1'b0));
		add_step(poll_row(32'd70710, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < steps.size(); i++) begin
			if (steps[i].is_cfg) begin
				settle();
				write_reg(steps[i].idx, steps[i].val);
			end else begin
				send_poll(steps[i]);
			end
		end

		// random phases: all low, all high, then mixed settings
		t_now = 32'd70710;
		pin_raw = 1'b1;
		for (ph = 0; ph < NumPhases; ph++) begin
			for (r = 0; r < 6; r++) begin
				ri = reg_idx_t'(r);
				wide = (ri == REG_HOLD_TIME || ri == REG_REPEAT_TIME || ri == REG_DC_WINDOW);
				if (ph == 0)
					v = 32'd0;
				else if (ph == 1)
					v = wide ? 32'hFFFF : 32'd1;
				else if (!wide)
					v = $urandom_range(0, 1);
				else begin
					case ($urandom_range(0, 3))
						0: v = 32'd0;
						1: v = 32'hFFFF;
						2: v = $urandom_range(1, 150);
						default: v = $urandom_range(1, 2000);
					endcase
				end
				settle();
				write_reg(ri, v);
			end
			for (k = 0; k < PollsPerPhase; k++) begin
				// one pause mid-phase until every event is out
				if (ph == 2 && k == PollsPerPhase / 2)
					settle();
				sel = $urandom_range(0, 19);
				if (sel < 12)
					t_now = t_now + $urandom_range(0, 40);
				else if (sel < 17)
					t_now = t_now + $urandom_range(0, 400);
				else if (sel == 17)
					t_now = t_now + $urandom_range(0, 3000);
				else if (sel == 18)
					t_now = t_now + $urandom_range(0, 70000);
				else
					t_now = $urandom;
				if ($urandom_range(0, 19) < 7)
					pin_raw = ~pin_raw;
				send_poll(poll_row(t_now, pin_raw));
			end
		end

		settle();
		if (n_bad == 0)
			$display("PASS button_gesture_detector");
		else
			$display("FAIL button_gesture_detector");
		$finish;
	end

endmodule
